// ===== sv/pfr_pkg.sv =====
// Shared types and constants for the two-objective Pareto front ranker.
`timescale 1ns / 1ps

package pfr_pkg;

    localparam int KEY_W   = 32;
    localparam int INDEX_W = 6;
    localparam int RANK_W  = 6;

    typedef struct packed {
        logic signed [KEY_W-1:0] objective_one;
        logic signed [KEY_W-1:0] objective_two;
        logic                    final_point;
    } t_point_in;

    typedef struct packed {
        logic [INDEX_W-1:0] point_index;
        logic [RANK_W-1:0]  front_rank;
        logic               last_result;
    } t_rank_out;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_one;
        logic signed [KEY_W-1:0] key_two;
    } t_key;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_EMIT,
        ST_EMIT_DRAIN
    } t_state;

    typedef struct packed {
        logic load;
        logic init;
        logic issue_scan;
        logic issue_emit;
        logic commit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic cand_valid;
    } t_status;

endpackage

// ===== sv/pfr_ctrl.sv =====
// Sequencer for loading, ranking passes and result emission.
`timescale 1ns / 1ps

module pfr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_final,
    input  pfr_pkg::t_status i_status,
    output pfr_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    pfr_pkg::t_state r_state;
    pfr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != pfr_pkg::ST_IDLE);
        case (r_state)
            pfr_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_final) begin
                        o_cmd.init = 1'b1;
                        n_state    = pfr_pkg::ST_SCAN;
                    end
                end
            end
            pfr_pkg::ST_SCAN: begin
                o_cmd.issue_scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = pfr_pkg::ST_DRAIN;
                end
            end
            pfr_pkg::ST_DRAIN: begin
                n_state = pfr_pkg::ST_COMMIT;
            end
            pfr_pkg::ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                if (i_status.cand_valid) begin
                    n_state = pfr_pkg::ST_SCAN;
                end else begin
                    n_state = pfr_pkg::ST_EMIT;
                end
            end
            pfr_pkg::ST_EMIT: begin
                o_cmd.issue_emit = 1'b1;
                if (i_status.scan_last) begin
                    n_state = pfr_pkg::ST_EMIT_DRAIN;
                end
            end
            pfr_pkg::ST_EMIT_DRAIN: begin
                o_cmd.finish = 1'b1;
                n_state      = pfr_pkg::ST_IDLE;
            end
            default: begin
                n_state = pfr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/pfr_datapath.sv =====
// Point and rank stores, dominance comparator and lexicographic minimum search.
`timescale 1ns / 1ps

module pfr_datapath #(
    parameter int MAX_POINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pfr_pkg::t_cmd      i_cmd,
    input  pfr_pkg::t_point_in i_point,
    output pfr_pkg::t_status   o_status,
    output pfr_pkg::t_rank_out o_result,
    output logic               o_strobe
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = pfr_pkg::INDEX_W;
    localparam int RW = pfr_pkg::RANK_W;

    pfr_pkg::t_key   r_pt_mem   [MAX_POINTS];
    logic [RW-1:0]   r_rank_mem [MAX_POINTS];

    logic [CW-1:0]         r_count;
    logic [MAX_POINTS-1:0] r_done;
    logic [AW-1:0]         r_scan;
    logic                  r_pipe_valid;
    logic                  r_emit_valid;
    logic                  r_emit_last;
    logic [AW-1:0]         r_pipe_idx;
    pfr_pkg::t_key         r_rd_pt;
    logic [RW-1:0]         r_rd_rank;
    logic                  r_cur_valid;
    logic [AW-1:0]         r_cur_idx;
    pfr_pkg::t_key         r_cur_key;
    logic                  r_cand_valid;
    logic [AW-1:0]         r_cand_idx;
    pfr_pkg::t_key         r_cand_key;
    logic [RW-1:0]         r_best;

    logic          not_full;
    logic          scan_last;
    logic          dominates;
    logic          take_cand;
    logic [RW-1:0] rank_plus;

    assign not_full  = (r_count < CW'(MAX_POINTS));
    assign scan_last = (r_scan == AW'(r_count - 1'b1));
    assign rank_plus = r_rd_rank + 1'b1;

    // j dominates the current point: no worse in both keys, better in one
    assign dominates = r_cur_valid && r_done[r_pipe_idx]
                       && (r_rd_pt.key_one <= r_cur_key.key_one)
                       && (r_rd_pt.key_two <= r_cur_key.key_two)
                       && ((r_rd_pt.key_one < r_cur_key.key_one)
                           || (r_rd_pt.key_two < r_cur_key.key_two));

    assign take_cand = !r_done[r_pipe_idx]
                       && !(r_cur_valid && (r_pipe_idx == r_cur_idx))
                       && (!r_cand_valid
                           || (r_rd_pt.key_one < r_cand_key.key_one)
                           || ((r_rd_pt.key_one == r_cand_key.key_one)
                               && (r_rd_pt.key_two < r_cand_key.key_two)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && not_full) begin
            r_pt_mem[r_count[AW-1:0]] <= '{key_one: i_point.objective_one,
                                           key_two: i_point.objective_two};
        end
        if (i_cmd.commit && r_cur_valid) begin
            r_rank_mem[r_cur_idx] <= r_best;
        end
        if (i_cmd.issue_scan) begin
            r_rd_pt <= r_pt_mem[r_scan];
        end
        if (i_cmd.issue_scan || i_cmd.issue_emit) begin
            r_rd_rank   <= r_rank_mem[r_scan];
            r_pipe_idx  <= r_scan;
            r_emit_last <= scan_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_done       <= '0;
            r_scan       <= '0;
            r_pipe_valid <= 1'b0;
            r_emit_valid <= 1'b0;
            r_cur_valid  <= 1'b0;
            r_cand_valid <= 1'b0;
        end else begin
            r_pipe_valid <= i_cmd.issue_scan;
            r_emit_valid <= i_cmd.issue_emit;
            if (i_cmd.finish) begin
                r_count <= '0;
            end else if (i_cmd.load && not_full) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.init) begin
                r_done       <= '0;
                r_scan       <= '0;
                r_cur_valid  <= 1'b0;
                r_cand_valid <= 1'b0;
            end else if (i_cmd.commit) begin
                if (r_cur_valid) begin
                    r_done[r_cur_idx] <= 1'b1;
                end
                r_scan       <= '0;
                r_cur_valid  <= r_cand_valid;
                r_cand_valid <= 1'b0;
            end else begin
                if (i_cmd.issue_scan || i_cmd.issue_emit) begin
                    r_scan <= r_scan + 1'b1;
                end
                if (r_pipe_valid && take_cand) begin
                    r_cand_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_cur_idx <= r_cand_idx;
            r_cur_key <= r_cand_key;
            r_best    <= '0;
        end else if (r_pipe_valid) begin
            if (take_cand) begin
                r_cand_idx <= r_pipe_idx;
                r_cand_key <= r_rd_pt;
            end
            if (dominates && (rank_plus > r_best)) begin
                r_best <= rank_plus;
            end
        end
    end

    assign o_status.scan_last  = scan_last;
    assign o_status.cand_valid = r_cand_valid;

    assign o_strobe             = r_emit_valid;
    assign o_result.point_index = IW'(r_pipe_idx);
    assign o_result.front_rank  = r_rd_rank;
    assign o_result.last_result = r_emit_last;

endmodule

// ===== sv/pareto_front_ranking.sv =====
// Two-objective Pareto front ranking top level.
// Loading: one point per cycle, busy stays low until the final point is taken.
// Ranking: points are settled in lexicographic key order, one full pass over the point
// store per point plus an initial pass, through a single dominance comparator.
// Emission: n results on consecutive cycles after the ranking.
// Synchronous active-low reset clears the point count, settled marks and controller.
`timescale 1ns / 1ps

module pareto_front_ranking #(
    parameter int MAX_POINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pfr_pkg::t_point_in i_point,
    output logic               o_strobe,
    output pfr_pkg::t_rank_out o_result
);

    pfr_pkg::t_cmd    cmd;
    pfr_pkg::t_status status;

    pfr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_final  (i_point.final_point),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    pfr_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_point  (i_point),
        .o_status (status),
        .o_result (o_result),
        .o_strobe (o_strobe)
    );

endmodule
